// File: rtl/sor_pkg.sv
// Package for the SOR linear solver: widths, function codes, status codes
// and the shared request/response types of the arithmetic unit.
// No dependencies.
`default_nettype none
package sor_pkg;
  localparam int MaxUnknowns = 8;
  localparam int IdxBits = 3;
  localparam int ValueBits = 32;

  typedef enum logic [1:0] {
    FuncLoadCoef = 2'd0,
    FuncLoadRhs = 2'd1,
    FuncLoadGuess = 2'd2,
    FuncSolve = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatConverged = 2'd0,
    StatCapReached = 2'd1,
    StatZeroDiag = 2'd2
  } status_e;

  localparam logic [1:0] RegSize = 2'd0;
  localparam logic [1:0] RegTol = 2'd1;
  localparam logic [1:0] RegRelax = 2'd2;
  localparam logic [1:0] RegCap = 2'd3;

  localparam logic signed [63:0] ResLim = 64'sd549755813887;
  localparam logic signed [31:0] VMax = 32'sh7fffffff;
  localparam logic signed [31:0] VMin = -32'sh7fffffff - 32'sd1;

  // divider request: dividend, divisor, start strobe
  typedef struct packed {
    logic start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(VMax)) return VMax;
    if (v < 66'(VMin)) return VMin;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/sor_div.sv
// Sequential signed divider, one quotient bit per cycle, truncation toward
// zero, saturated to 32 bits. Depends on sor_pkg.
`default_nettype none
module sor_div (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sor_pkg::div_req_t req_i,
  output sor_pkg::div_rsp_t rsp_o
);
  import sor_pkg::*;

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] dvd_q, dvd_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic signed [31:0] res_q, res_d;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic signed [65:0] sq;

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q;
    dvd_d = dvd_q; neg_d = neg_q; done_d = 1'b0; res_d = res_q;
    rem_sh = {rem_q[62:0], quo_q[63]};
    trial = {1'b0, rem_sh} - {33'b0, dvd_q};
    sq = 66'sd0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 7'd0;
      rem_d = '0;
      quo_d = req_i.num[63] ? 64'(-req_i.num) : 64'(req_i.num);
      dvd_d = req_i.den[31] ? 32'(-req_i.den) : 32'(req_i.den);
      neg_d = req_i.num[63] ^ req_i.den[31];
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        sq = neg_q ? -$signed({2'b0, quo_d}) : $signed({2'b0, quo_d});
        res_d = sat32(sq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvd_q <= dvd_d; neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o = {done_q, res_q};

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> cnt_q == 7'd0) else $error("bad divider start");
`endif
endmodule
`default_nettype wire

// File: rtl/sor_linear_solver.sv
// SOR linear solver top level: stores, sequencer, shared multiplier and
// divider. Depends on sor_pkg and sor_div.
//
//  channel  | ports                                  | flow
//  request  | start_i busy_o func_i row_i col_i value_i | taken when start_i & !busy_o
//  result   | res_valid_o index_o solution_o sweeps_done_o status_o last_o | one-cycle strobe
//  config   | cfg_we_i cfg_idx_i cfg_data_i          | written on any cycle cfg_we_i is high
//
// A load request writes its value on acceptance and leaves busy_o low. A
// solve squares the tolerance, checks the diagonals and decides; then each
// unknown per sweep runs multiply-accumulate steps over the one shared 33x33
// multiplier, a diagonal read, a division and the relax and square states.
// Results follow at one per cycle, then the StEmitOut state before busy_o
// drops. Reset clears the unknowns and counters and sets the configuration
// registers to their defaults; coefficient and rhs contents stay undefined
// until written. The receiver cannot stall.
`default_nettype none
module sor_linear_solver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  row_i,
  input  wire logic [2:0]  col_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_data_i,
  output logic             res_valid_o,
  output logic [2:0]       index_o,
  output logic signed [31:0] solution_o,
  output logic [15:0]      sweeps_done_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  import sor_pkg::*;

  localparam logic [3:0] StIdle = 4'd0, StDiag = 4'd1, StMac = 4'd2,
    StMacAcc = 4'd3, StDiv = 4'd4, StDivWait = 4'd5, StRelax = 4'd6,
    StRelaxAcc = 4'd7, StSq = 4'd8, StSqAcc = 4'd9, StCheck = 4'd10,
    StEmit = 4'd11, StEmitOut = 4'd12, StTol = 4'd13, StDivRd = 4'd14;

  logic signed [31:0] coef_mem [MaxUnknowns*MaxUnknowns];
  logic signed [31:0] rhs_q [MaxUnknowns];
  logic signed [31:0] x_q [MaxUnknowns];

  logic [3:0] size_q;
  logic [30:0] tol_q;
  logic [25:0] relax_q;
  logic [15:0] cap_q;

  logic [3:0] st_q;
  logic [2:0] i_q, j_q, n_m1_q;
  logic signed [63:0] sum_q;
  logic signed [31:0] coef_rd_q;
  logic [63:0] acc_q, tol2_q;
  logic [15:0] sweep_q;
  logic [1:0] stat_q;
  logic signed [63:0] prod_q;
  logic signed [32:0] diff_q;
  logic [32:0] mag_q;
  logic diag_zero_q;

  // shared multiplier, 33x33 signed
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  div_req_t dreq;
  div_rsp_t drsp;
  sor_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (st_q != StIdle);

  logic [5:0] rd_addr;
  logic signed [63:0] res_c;
  logic signed [65:0] nx_w;
  logic [63:0] sqv, acc_n;
  logic [64:0] acc_sum;

  always_comb begin
    rd_addr = {i_q, j_q};
    mul_a = 33'(coef_rd_q);
    mul_b = 33'(x_q[j_q]);
    case (st_q)
      StRelax: begin mul_a = diff_q; mul_b = $signed({7'b0, relax_q}); end
      StSq: begin mul_a = $signed(mag_q); mul_b = $signed(mag_q); end
      StTol: begin mul_a = $signed({2'b0, tol_q}); mul_b = $signed({2'b0, tol_q}); end
      default: ;
    endcase
    res_c = 64'(rhs_q[i_q]) - sum_q;
    if (res_c > ResLim) res_c = ResLim;
    if (res_c < -ResLim) res_c = -ResLim;
    dreq.start = (st_q == StDiv);
    dreq.num = res_c <<< 24;
    dreq.den = coef_rd_q;
    nx_w = 66'(x_q[i_q]) + (prod_q >>> 24);
    sqv = prod_q[63:0];
    acc_sum = {1'b0, acc_q} + {1'b0, sqv};
    acc_n = (mag_q[32] || acc_sum[64]) ? '1 : acc_sum[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept && func_i == FuncLoadCoef) coef_mem[{row_i, col_i}] <= value_i;
    coef_rd_q <= coef_mem[rd_addr];
    if (accept && func_i == FuncLoadRhs) rhs_q[row_i] <= value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxUnknowns; k++) x_q[k] <= '0;
      size_q <= 4'd8; tol_q <= 31'd17; relax_q <= 26'd16777216; cap_q <= 16'd1000;
      st_q <= StIdle; i_q <= '0; j_q <= '0; n_m1_q <= '0; sum_q <= '0;
      acc_q <= '0; tol2_q <= '0; sweep_q <= '0; stat_q <= StatConverged;
      prod_q <= '0; diff_q <= '0; mag_q <= '0; diag_zero_q <= 1'b0;
      res_valid_o <= 1'b0; index_o <= '0; solution_o <= '0;
      sweeps_done_o <= '0; status_o <= '0; last_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSize: size_q <= cfg_data_i[3:0];
          RegTol: tol_q <= cfg_data_i;
          RegRelax: relax_q <= cfg_data_i[25:0];
          RegCap: cap_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (st_q)
        StIdle: if (accept) begin
          if (func_i == FuncLoadGuess) x_q[row_i] <= value_i;
          if (func_i == FuncSolve) begin
            n_m1_q <= (size_q == 4'd0) ? 3'd0 : (size_q > 4'd8) ? 3'd7 : 3'(size_q - 4'd1);
            i_q <= '0; j_q <= '0; sweep_q <= '0; acc_q <= '0; diag_zero_q <= 1'b0;
            st_q <= StTol;
          end
        end
        StTol: begin
          tol2_q <= mul_p[63:0];
          st_q <= StDiag;
        end
        StDiag: begin
          // address {i,i} registered; compare on the following visit
          if (j_q == i_q && acc_q == 64'd1) begin
            if (coef_rd_q == 32'sd0) diag_zero_q <= 1'b1;
            acc_q <= '0;
            if (i_q == n_m1_q) begin
              i_q <= '0; j_q <= '0;
              st_q <= StCheck;
            end else begin
              i_q <= i_q + 3'd1; j_q <= i_q + 3'd1;
            end
          end else if (j_q == i_q) acc_q <= 64'd1;
        end
        StCheck: begin
          if (diag_zero_q) begin
            stat_q <= StatZeroDiag; i_q <= '0; st_q <= StEmit;
          end else begin
            acc_q <= '0; i_q <= '0; j_q <= '0; sum_q <= '0; st_q <= StMac;
          end
        end
        StMac: st_q <= StMacAcc;   // coefficient read settles
        StMacAcc: begin
          if (j_q != i_q) sum_q <= sum_q + 64'(mul_p >>> 24);
          if (j_q == n_m1_q) begin
            j_q <= i_q; st_q <= StDivRd;
          end else begin
            j_q <= j_q + 3'd1; st_q <= StMac;
          end
        end
        StDivRd: st_q <= StDiv;    // diagonal read settles
        StDiv: st_q <= StDivWait;
        StDivWait: if (drsp.done) begin
          diff_q <= 33'(drsp.quot) - 33'(x_q[i_q]);
          st_q <= StRelax;
        end
        StRelax: begin prod_q <= mul_p[63:0]; st_q <= StRelaxAcc; end
        StRelaxAcc: begin
          x_q[i_q] <= sat32(nx_w);
          mag_q <= (sat32(nx_w) >= x_q[i_q]) ?
            33'(34'(sat32(nx_w)) - 34'(x_q[i_q])) :
            33'(34'(x_q[i_q]) - 34'(sat32(nx_w)));
          st_q <= StSq;
        end
        StSq: begin prod_q <= mul_p[63:0]; st_q <= StSqAcc; end
        StSqAcc: begin
          sum_q <= '0; j_q <= '0;
          if (i_q == n_m1_q) begin
            i_q <= '0;
            sweep_q <= sweep_q + 16'd1;
            if (acc_n <= tol2_q) begin
              acc_q <= acc_n; stat_q <= StatConverged; st_q <= StEmit;
            end else if (sweep_q + 16'd1 >= ((cap_q == 16'd0) ? 16'd1 : cap_q)) begin
              acc_q <= acc_n; stat_q <= StatCapReached; st_q <= StEmit;
            end else begin acc_q <= '0; st_q <= StMac; end
          end else begin
            acc_q <= acc_n; i_q <= i_q + 3'd1; st_q <= StMac;
          end
        end
        StEmit: begin
          res_valid_o <= 1'b1; index_o <= i_q; solution_o <= x_q[i_q];
          sweeps_done_o <= sweep_q; status_o <= stat_q; last_o <= (i_q == n_m1_q);
          if (i_q == n_m1_q) st_q <= StEmitOut;
          else i_q <= i_q + 3'd1;
        end
        StEmitOut: st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |=> !res_valid_o) else $error("result after last");
  a_zero_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == StatZeroDiag |-> sweeps_done_o == 16'd0)
    else $error("zero diagonal with sweeps");
  a_busy_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o)) else $error("result while idle");
`endif
endmodule
`default_nettype wire
